// ===== hw/rtl/match_block_merger_unit_assert.svh =====
// Assertion macros for the match block merger unit
`ifndef MATCH_BLOCK_MERGER_UNIT_ASSERT_SVH
`define MATCH_BLOCK_MERGER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define MBM_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define MBM_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define MBM_ASSERT(lbl, clk, rstn, prop, msg)
`define MBM_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/mbm_pkg.sv =====
// Shared types, constants and register codes of the match block merger
package mbm_pkg;

	localparam int POS_W = 32;
	localparam int CNT_W = 16;
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int MAX_MIN_HITS_DEFAULT = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_MERGE_DISTANCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_BLOCK_HITS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RECYCLE_ENABLE = 2'd3;

	localparam logic [15:0] MERGE_DISTANCE_RST = 16'd200;
	localparam logic [4:0] MIN_BLOCK_HITS_RST = 5'd2;
	localparam logic [7:0] PATTERN_LENGTH_RST = 8'd6;
	localparam logic RECYCLE_ENABLE_RST = 1'b0;

	localparam logic [1:0] LABEL_P = 2'd0;
	localparam logic [1:0] LABEL_Q = 2'd1;
	localparam logic [1:0] LABEL_U = 2'd2;

	localparam logic KIND_BLOCK = 1'b0;
	localparam logic KIND_RECYCLE = 1'b1;

	typedef struct packed {
		logic capture;
		logic open_blk;
		logic add_hit;
		logic load_report;
		logic load_recycle;
		logic rd_issue;
		logic close_done;
		logic run_last;
	} cmd_t;

	typedef struct packed {
		logic block_open;
		logic gap_ok;
		logic last_in;
		logic reportable;
		logic recycle_en;
		logic fill_nonzero;
		logic rd_last;
		logic single_emits;
		logic out_free;
	} sts_t;

endpackage

// ===== hw/rtl/mbm_ifs.sv =====
// Item channel interfaces: hits in, results out
interface mbm_hit_if;
	logic valid;
	logic ready;
	logic [mbm_pkg::POS_W-1:0] hit_position;
	logic hit_forward;
	logic hit_canonical;
	logic stream_end;

	modport source(output valid, hit_position, hit_forward, hit_canonical, stream_end,
		input ready);
	modport sink(input valid, hit_position, hit_forward, hit_canonical, stream_end,
		output ready);
endinterface

interface mbm_result_if;
	logic valid;
	logic ready;
	logic result_kind;
	logic [mbm_pkg::POS_W-1:0] block_start;
	logic [mbm_pkg::POS_W-1:0] block_length;
	logic [mbm_pkg::CNT_W-1:0] hit_count;
	logic [mbm_pkg::CNT_W-1:0] forward_hits;
	logic [mbm_pkg::CNT_W-1:0] canonical_hits;
	logic [1:0] arm_label;
	logic [mbm_pkg::POS_W-1:0] recycled_position;
	logic recycled_forward;
	logic recycled_canonical;
	logic run_last;

	modport source(output valid, result_kind, block_start, block_length, hit_count,
		forward_hits, canonical_hits, arm_label, recycled_position, recycled_forward,
		recycled_canonical, run_last, input ready);
	modport sink(input valid, result_kind, block_start, block_length, hit_count,
		forward_hits, canonical_hits, arm_label, recycled_position, recycled_forward,
		recycled_canonical, run_last, output ready);
endinterface

// ===== hw/rtl/mbm_datapath.sv =====
// Datapath: config registers, open block state, pending hit buffer, result register
`include "match_block_merger_unit_assert.svh"
module mbm_datapath #(
	parameter int MAX_MIN_HITS = mbm_pkg::MAX_MIN_HITS_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mbm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mbm_pkg::CFG_W-1:0]         cfg_data,
	input  logic [mbm_pkg::POS_W-1:0]         hit_position,
	input  logic                              hit_forward,
	input  logic                              hit_canonical,
	input  logic                              stream_end,
	input  mbm_pkg::cmd_t                     cmd,
	output mbm_pkg::sts_t                     sts,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              result_kind,
	output logic [mbm_pkg::POS_W-1:0]         block_start,
	output logic [mbm_pkg::POS_W-1:0]         block_length,
	output logic [mbm_pkg::CNT_W-1:0]         hit_count,
	output logic [mbm_pkg::CNT_W-1:0]         forward_hits,
	output logic [mbm_pkg::CNT_W-1:0]         canonical_hits,
	output logic [1:0]                        arm_label,
	output logic [mbm_pkg::POS_W-1:0]         recycled_position,
	output logic                              recycled_forward,
	output logic                              recycled_canonical,
	output logic                              run_last
);

	localparam int PEND = MAX_MIN_HITS - 1;
	localparam int FILL_W = $clog2(MAX_MIN_HITS);
	localparam int ADDR_W = (PEND > 1) ? $clog2(PEND) : 1;
	localparam int POS_W = mbm_pkg::POS_W;
	localparam int CNT_W = mbm_pkg::CNT_W;
	// forward*100 and count*66 of a 16-bit count fit in 23 bits
	localparam int LBL_W = CNT_W + 7;

	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic fwd;
		logic can;
	} entry_t;

	// configuration
	logic [15:0] merge_distance_q;
	logic [4:0] min_block_hits_q;
	logic [7:0] pattern_length_q;
	logic recycle_enable_q;

	// latched hit
	logic [POS_W-1:0] pos_q;
	logic fwd_q;
	logic can_q;
	logic last_q;

	// open block
	logic block_open_q;
	logic [POS_W-1:0] start_q;
	logic [POS_W-1:0] prev_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] fwd_cnt_q;
	logic [CNT_W-1:0] can_cnt_q;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] rd_idx_q;

	entry_t pend_mem [PEND];
	entry_t rd_q;
	logic mem_we;
	logic [ADDR_W-1:0] mem_addr;

	logic [POS_W-1:0] gap;
	logic [CNT_W-1:0] min16;
	logic [CNT_W-1:0] need;
	logic [LBL_W-1:0] f100;
	logic [LBL_W-1:0] c66;
	logic [LBL_W-1:0] c33;
	logic [1:0] label;
	logic out_valid_q;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v, input logic a);
		return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(a);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			merge_distance_q <= mbm_pkg::MERGE_DISTANCE_RST;
			min_block_hits_q <= mbm_pkg::MIN_BLOCK_HITS_RST;
			pattern_length_q <= mbm_pkg::PATTERN_LENGTH_RST;
			recycle_enable_q <= mbm_pkg::RECYCLE_ENABLE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mbm_pkg::CFG_MERGE_DISTANCE: merge_distance_q <= cfg_data[15:0];
				mbm_pkg::CFG_MIN_BLOCK_HITS: min_block_hits_q <= cfg_data[4:0];
				mbm_pkg::CFG_PATTERN_LENGTH: pattern_length_q <= cfg_data[7:0];
				mbm_pkg::CFG_RECYCLE_ENABLE: recycle_enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pos_q <= hit_position;
			fwd_q <= hit_forward;
			can_q <= hit_canonical;
			last_q <= stream_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_open_q <= 1'b0;
			fill_q <= '0;
			rd_idx_q <= '0;
			count_q <= '0;
			fwd_cnt_q <= '0;
			can_cnt_q <= '0;
			start_q <= '0;
			prev_q <= '0;
		end else begin
			if (cmd.open_blk) begin
				block_open_q <= 1'b1;
				start_q <= pos_q;
				prev_q <= pos_q;
				count_q <= CNT_W'(1);
				fwd_cnt_q <= CNT_W'(fwd_q);
				can_cnt_q <= CNT_W'(can_q);
				fill_q <= FILL_W'(1);
				rd_idx_q <= '0;
			end else if (cmd.add_hit) begin
				count_q <= sat_inc(count_q, 1'b1);
				fwd_cnt_q <= sat_inc(fwd_cnt_q, fwd_q);
				can_cnt_q <= sat_inc(can_cnt_q, can_q);
				prev_q <= pos_q;
				if (fill_q < FILL_W'(PEND)) begin
					fill_q <= fill_q + 1'b1;
				end
			end else if (cmd.close_done) begin
				block_open_q <= 1'b0;
				fill_q <= '0;
				rd_idx_q <= '0;
			end else if (cmd.load_recycle) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
		end
	end

	// hits past the buffer depth are never needed: such a block is not undersized
	assign mem_we = cmd.open_blk || (cmd.add_hit && (fill_q < FILL_W'(PEND)));
	assign mem_addr = cmd.open_blk ? '0 : fill_q[ADDR_W-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			pend_mem[mem_addr] <= '{pos: pos_q, fwd: fwd_q, can: can_q};
		end
		if (cmd.rd_issue) begin
			rd_q <= pend_mem[rd_idx_q[ADDR_W-1:0]];
		end
	end

	always_comb begin
		gap = pos_q - prev_q;
		min16 = CNT_W'(min_block_hits_q);
		need = (min16 > CNT_W'(MAX_MIN_HITS)) ? CNT_W'(MAX_MIN_HITS) : min16;
		f100 = LBL_W'(fwd_cnt_q) * LBL_W'(100);
		c66 = LBL_W'(count_q) * LBL_W'(66);
		c33 = LBL_W'(count_q) * LBL_W'(33);
		if (f100 > c66) begin
			label = mbm_pkg::LABEL_P;
		end else if (f100 < c33) begin
			label = mbm_pkg::LABEL_Q;
		end else begin
			label = mbm_pkg::LABEL_U;
		end
	end

	always_comb begin
		sts.block_open = block_open_q;
		sts.gap_ok = gap <= POS_W'(merge_distance_q);
		sts.last_in = last_q;
		sts.reportable = count_q >= need;
		sts.recycle_en = recycle_enable_q;
		sts.fill_nonzero = fill_q != '0;
		sts.rd_last = FILL_W'(rd_idx_q + 1'b1) == fill_q;
		sts.single_emits = (need <= CNT_W'(1)) || recycle_enable_q;
		sts.out_free = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_report || cmd.load_recycle) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_report) begin
			result_kind <= mbm_pkg::KIND_BLOCK;
			block_start <= start_q;
			block_length <= prev_q - start_q + POS_W'(pattern_length_q);
			hit_count <= count_q;
			forward_hits <= fwd_cnt_q;
			canonical_hits <= can_cnt_q;
			arm_label <= label;
			recycled_position <= '0;
			recycled_forward <= 1'b0;
			recycled_canonical <= 1'b0;
			run_last <= cmd.run_last;
		end else if (cmd.load_recycle) begin
			result_kind <= mbm_pkg::KIND_RECYCLE;
			block_start <= '0;
			block_length <= '0;
			hit_count <= '0;
			forward_hits <= '0;
			canonical_hits <= '0;
			arm_label <= mbm_pkg::LABEL_P;
			recycled_position <= rd_q.pos;
			recycled_forward <= rd_q.fwd;
			recycled_canonical <= rd_q.can;
			run_last <= cmd.run_last;
		end
	end

	assign out_valid = out_valid_q;

	`MBM_ASSERT(a_fill_bound, clk, arst_n, fill_q <= FILL_W'(PEND), "pending fill past depth")
	`MBM_ASSERT_IMPL(a_rd_in_fill, clk, arst_n, cmd.rd_issue, rd_idx_q < fill_q, "read past fill")

endmodule

// ===== hw/rtl/mbm_ctrl.sv =====
// Controller: sequences accept, merge decision, block close and recycle drain
`include "match_block_merger_unit_assert.svh"
module mbm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  mbm_pkg::sts_t sts,
	output mbm_pkg::cmd_t cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EVAL  = 3'd1;
	localparam logic [2:0] ST_CLOSE = 3'd2;
	localparam logic [2:0] ST_RD    = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;
	localparam logic [2:0] ST_POST  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic reopen_q;
	logic reopen_d;
	logic more;

	// the reopened single-hit block will close again and give one more item
	assign more = reopen_q && sts.last_in && sts.single_emits;

	always_comb begin
		state_d = state_q;
		reopen_d = reopen_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (!sts.block_open) begin
					cmd.open_blk = 1'b1;
					state_d = sts.last_in ? ST_CLOSE : ST_IDLE;
				end else if (sts.gap_ok) begin
					cmd.add_hit = 1'b1;
					state_d = sts.last_in ? ST_CLOSE : ST_IDLE;
				end else begin
					reopen_d = 1'b1;
					state_d = ST_CLOSE;
				end
			end
			ST_CLOSE: begin
				if (sts.reportable) begin
					if (sts.out_free) begin
						cmd.load_report = 1'b1;
						cmd.run_last = !more;
						state_d = ST_POST;
					end
				end else if (sts.recycle_en && sts.fill_nonzero) begin
					cmd.rd_issue = 1'b1;
					state_d = ST_EMIT;
				end else begin
					state_d = ST_POST;
				end
			end
			ST_RD: begin
				cmd.rd_issue = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.load_recycle = 1'b1;
					cmd.run_last = sts.rd_last && !more;
					state_d = sts.rd_last ? ST_POST : ST_RD;
				end
			end
			ST_POST: begin
				if (reopen_q) begin
					cmd.open_blk = 1'b1;
					reopen_d = 1'b0;
					state_d = sts.last_in ? ST_CLOSE : ST_IDLE;
				end else begin
					cmd.close_done = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			reopen_q <= 1'b0;
		end else begin
			state_q <= state_d;
			reopen_q <= reopen_d;
		end
	end

	`MBM_ASSERT_IMPL(a_load_free, clk, arst_n, cmd.load_report || cmd.load_recycle, sts.out_free, "result load over held item")
	`MBM_ASSERT_IMPL(a_idle_clean, clk, arst_n, state_q == ST_IDLE, !reopen_q, "reopen left pending")
	`MBM_ASSERT_IMPL(a_emit_src, clk, arst_n, state_q == ST_EMIT, $past(state_q) == ST_CLOSE || $past(state_q) == ST_RD || $past(state_q) == ST_EMIT, "emit without read")
	`MBM_ASSERT_IMPL(a_open_once, clk, arst_n, cmd.open_blk, !cmd.add_hit && !cmd.close_done, "conflicting block commands")

endmodule

// ===== hw/rtl/match_block_merger_unit.sv =====
// Top level of the match block merger: hit stream in, block reports and recycled hits out
//
// Takes a position-sorted stream of hits and groups neighbors whose gap is at most
// merge_distance into blocks. A hit that joins or opens a block goes through the idle and
// evaluate states before the next is accepted. Closing a block, reported or dropped, adds
// the close and post states; recycling instead emits pending hits one at a time (the
// buffer has one registered read port), and a gap-closed block that ends the stream closes
// twice. Results leave through an output register, so the block keeps taking hits while
// a result waits; the controller stalls only when it must load a new result and the
// register is still held. The last result caused by one hit carries run_last.
// Configuration registers may be written only while no hit is in progress.
module match_block_merger_unit #(
	parameter int MAX_MIN_HITS = mbm_pkg::MAX_MIN_HITS_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	mbm_hit_if.sink                       hit,
	mbm_result_if.source                  result,
	input  logic                          cfg_we,
	input  logic [mbm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mbm_pkg::CFG_W-1:0]     cfg_data
);

	mbm_pkg::cmd_t cmd;
	mbm_pkg::sts_t sts;

	mbm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (hit.valid),
		.in_ready (hit.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mbm_datapath #(
		.MAX_MIN_HITS (MAX_MIN_HITS)
	) u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.hit_position       (hit.hit_position),
		.hit_forward        (hit.hit_forward),
		.hit_canonical      (hit.hit_canonical),
		.stream_end         (hit.stream_end),
		.cmd                (cmd),
		.sts                (sts),
		.out_valid          (result.valid),
		.out_ready          (result.ready),
		.result_kind        (result.result_kind),
		.block_start        (result.block_start),
		.block_length       (result.block_length),
		.hit_count          (result.hit_count),
		.forward_hits       (result.forward_hits),
		.canonical_hits     (result.canonical_hits),
		.arm_label          (result.arm_label),
		.recycled_position  (result.recycled_position),
		.recycled_forward   (result.recycled_forward),
		.recycled_canonical (result.recycled_canonical),
		.run_last           (result.run_last)
	);

endmodule

// ===== dv/block_merge_checker.sv =====
// Checker: follows the hit and result channels, predicts block merging and compares results
`timescale 1ns / 1ps
module block_merge_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	mbm_hit_if                            hit_mon,
	mbm_result_if                         res_mon,
	input  logic                          cfg_we,
	input  logic [mbm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mbm_pkg::CFG_W-1:0]     cfg_data,
	output int unsigned                   outstanding,
	output int unsigned                   mismatch_count
);
	import mbm_pkg::*;

	localparam int BUF_DEPTH = MAX_MIN_HITS_DEFAULT - 1;
	localparam logic [CNT_W-1:0] CNT_TOP = '1;

	typedef struct packed {
		logic             kind;
		logic [POS_W-1:0] start;
		logic [POS_W-1:0] length;
		logic [CNT_W-1:0] count;
		logic [CNT_W-1:0] fwd;
		logic [CNT_W-1:0] can;
		logic [1:0]       label;
		logic [POS_W-1:0] rpos;
		logic             rfwd;
		logic             rcan;
		logic             last;
	} merge_result_t;

	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic             fwd;
		logic             can;
	} held_hit_t;

	logic [15:0] gap_limit;
	logic [4:0] min_hits;
	logic [7:0] pat_len;
	logic recycle_on;

	logic blk_open;
	logic [POS_W-1:0] blk_start;
	logic [POS_W-1:0] last_pos;
	logic [CNT_W-1:0] n_hits;
	logic [CNT_W-1:0] n_fwd;
	logic [CNT_W-1:0] n_can;
	held_hit_t held [BUF_DEPTH];
	int unsigned held_fill;

	merge_result_t due_results[$];
	merge_result_t head;
	int unsigned errors;

	function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] v, logic b);
		return (v == CNT_TOP) ? v : v + CNT_W'(b);
	endfunction

	task automatic queue_result(merge_result_t r);
		due_results.insert(due_results.size(), r);
	endtask

	task automatic start_block(logic [POS_W-1:0] pos, logic fwd, logic can);
		blk_open = 1'b1;
		blk_start = pos;
		last_pos = pos;
		n_hits = 1;
		n_fwd = CNT_W'(fwd);
		n_can = CNT_W'(can);
		held[0] = '{pos, fwd, can};
		held_fill = 1;
	endtask

	task automatic join_block(logic [POS_W-1:0] pos, logic fwd, logic can);
		n_hits = sat_add(n_hits, 1'b1);
		n_fwd = sat_add(n_fwd, fwd);
		n_can = sat_add(n_can, can);
		last_pos = pos;
		if (held_fill < BUF_DEPTH) begin
			held[held_fill] = '{pos, fwd, can};
			held_fill++;
		end
	endtask

	task automatic close_block();
		int unsigned need;
		int unsigned f100;
		int unsigned i;
		merge_result_t r;
		if (!blk_open)
			return;
		blk_open = 1'b0;
		need = (min_hits > MAX_MIN_HITS_DEFAULT) ? MAX_MIN_HITS_DEFAULT : min_hits;
		if (n_hits >= need) begin
			r = '0;
			r.kind = KIND_BLOCK;
			r.start = blk_start;
			r.length = last_pos - blk_start + POS_W'(pat_len);
			r.count = n_hits;
			r.fwd = n_fwd;
			r.can = n_can;
			f100 = int'(n_fwd) * 100;
			if (f100 > 66 * int'(n_hits))
				r.label = LABEL_P;
			else if (f100 < 33 * int'(n_hits))
				r.label = LABEL_Q;
			else
				r.label = LABEL_U;
			queue_result(r);
		end else if (recycle_on) begin
			// re-emit buffered hits in arrival order
			for (i = 0; i < held_fill; i++) begin
				r = '0;
				r.kind = KIND_RECYCLE;
				r.rpos = held[i].pos;
				r.rfwd = held[i].fwd;
				r.rcan = held[i].can;
				queue_result(r);
			end
		end
		held_fill = 0;
	endtask

	task automatic predict_hit(logic [POS_W-1:0] pos, logic fwd, logic can, logic ends);
		int unsigned prior;
		logic [POS_W-1:0] gap;
		prior = due_results.size();
		gap = pos - last_pos;
		if (!blk_open) begin
			start_block(pos, fwd, can);
		end else if (gap <= POS_W'(gap_limit)) begin
			join_block(pos, fwd, can);
		end else begin
			close_block();
			start_block(pos, fwd, can);
		end
		if (ends)
			close_block();
		if (due_results.size() > prior)
			due_results[due_results.size() - 1].last = 1'b1;
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_limit = MERGE_DISTANCE_RST;
			min_hits = MIN_BLOCK_HITS_RST;
			pat_len = PATTERN_LENGTH_RST;
			recycle_on = RECYCLE_ENABLE_RST;
			blk_open = 1'b0;
			blk_start = '0;
			last_pos = '0;
			n_hits = '0;
			n_fwd = '0;
			n_can = '0;
			held_fill = 0;
			due_results.delete();
			errors = 0;
			outstanding <= 0;
			mismatch_count <= 0;
		end else begin
			if (res_mon.valid && res_mon.ready) begin
				if (due_results.size() == 0) begin
					$display("%0t: result expected none got kind %0h start %0h rpos %0h",
						$time, res_mon.result_kind, res_mon.block_start,
						res_mon.recycled_position);
					errors++;
				end else begin
					head = due_results.pop_front();
					check_field("result_kind", head.kind, res_mon.result_kind);
					check_field("block_start", head.start, res_mon.block_start);
					check_field("block_length", head.length, res_mon.block_length);
					check_field("hit_count", head.count, res_mon.hit_count);
					check_field("forward_hits", head.fwd, res_mon.forward_hits);
					check_field("canonical_hits", head.can, res_mon.canonical_hits);
					check_field("arm_label", head.label, res_mon.arm_label);
					check_field("recycled_position", head.rpos, res_mon.recycled_position);
					check_field("recycled_forward", head.rfwd, res_mon.recycled_forward);
					check_field("recycled_canonical", head.rcan, res_mon.recycled_canonical);
					check_field("run_last", head.last, res_mon.run_last);
				end
			end
			if (hit_mon.valid && hit_mon.ready)
				predict_hit(hit_mon.hit_position, hit_mon.hit_forward, hit_mon.hit_canonical,
					hit_mon.stream_end);
			if (cfg_we) begin
				case (cfg_index)
					CFG_MERGE_DISTANCE: gap_limit = cfg_data[15:0];
					CFG_MIN_BLOCK_HITS: min_hits = cfg_data[4:0];
					CFG_PATTERN_LENGTH: pat_len = cfg_data[7:0];
					CFG_RECYCLE_ENABLE: recycle_on = cfg_data[0];
					default: ;
				endcase
			end
			outstanding <= due_results.size();
			mismatch_count <= errors;
		end
	end
endmodule

// ===== dv/tb_top.sv =====
// Testbench top: drives hits, result back-pressure and register writes, and gives the verdict
`timescale 1ns / 1ps
module tb_top;
	import mbm_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 12;
	localparam int END_CYCLES = 20;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	int unsigned outstanding;
	int unsigned mismatch_count;
	int unsigned send_idle;
	int unsigned recv_idle;
	int unsigned quiet_cycles = 0;
	logic [POS_W-1:0] cur_pos;
	logic [15:0] gap_cfg;

	mbm_hit_if hit_ch();
	mbm_result_if res_ch();

	match_block_merger_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.hit(hit_ch),
		.result(res_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	block_merge_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.hit_mon(hit_ch),
		.res_mon(res_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.outstanding(outstanding),
		.mismatch_count(mismatch_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			res_ch.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((hit_ch.valid && hit_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_hit(logic [POS_W-1:0] pos, logic fwd, logic can, logic ends);
		while ($urandom_range(99) < send_idle) begin
			hit_ch.valid <= 1'b0;
			@(posedge clk);
		end
		hit_ch.valid <= 1'b1;
		hit_ch.hit_position <= pos;
		hit_ch.hit_forward <= fwd;
		hit_ch.hit_canonical <= can;
		hit_ch.stream_end <= ends;
		@(posedge clk);
		while (!hit_ch.ready)
			@(posedge clk);
	endtask

	task automatic wait_drained(int unsigned settle);
		hit_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_regs(logic [15:0] md, logic [15:0] mn, logic [15:0] pl,
		logic [15:0] re);
		cfg_we <= 1'b1;
		cfg_index <= CFG_MERGE_DISTANCE;
		cfg_data <= md;
		@(posedge clk);
		cfg_index <= CFG_MIN_BLOCK_HITS;
		cfg_data <= mn;
		@(posedge clk);
		cfg_index <= CFG_PATTERN_LENGTH;
		cfg_data <= pl;
		@(posedge clk);
		cfg_index <= CFG_RECYCLE_ENABLE;
		cfg_data <= re;
		@(posedge clk);
		cfg_we <= 1'b0;
		gap_cfg = md;
	endtask

	task automatic random_setting();
		logic [15:0] md;
		logic [15:0] mn;
		logic [15:0] pl;
		logic [15:0] re;
		case ($urandom_range(5))
			0: md = 16'd0;
			1: md = 16'hFFFF;
			5: md = 16'($urandom_range(65535));
			default: md = 16'($urandom_range(1, 400));
		endcase
		// upper bits are don't-care; randomize them
		mn = 16'($urandom_range(65535));
		case ($urandom_range(5))
			0: mn[4:0] = 5'd0;
			1: mn[4:0] = 5'd1;
			2: mn[4:0] = 5'd16;
			3: mn[4:0] = 5'($urandom_range(17, 31));
			default: mn[4:0] = 5'($urandom_range(2, 15));
		endcase
		pl = 16'($urandom_range(65535));
		case ($urandom_range(4))
			0: pl[7:0] = 8'd1;
			1: pl[7:0] = 8'd255;
			2: pl[7:0] = 8'd0;
			default: ;
		endcase
		re = 16'($urandom_range(65535));
		re[0] = ($urandom_range(9) < 7);
		write_regs(md, mn, pl, re);
	endtask

	// well-formed blocks of random size and content, with some position jumps as noise
	task automatic random_blocks(int unsigned n_items);
		int unsigned sent;
		int unsigned size;
		int unsigned k;
		int unsigned fwd_pct;
		int unsigned can_pct;
		int unsigned pick;
		logic [POS_W-1:0] step;
		logic ends;
		sent = 0;
		while (sent < n_items) begin
			size = ($urandom_range(9) == 0) ? $urandom_range(17, 24) : $urandom_range(1, 17);
			fwd_pct = $urandom_range(100);
			can_pct = $urandom_range(100);
			cur_pos = cur_pos + POS_W'(gap_cfg) + 1 + $urandom_range(3000);
			for (k = 0; k < size && sent < n_items; k++) begin
				pick = $urandom_range(99);
				if (k != 0) begin
					if (pick < 15)
						step = '0;
					else if (pick < 35)
						step = POS_W'(gap_cfg);
					else if (pick < 42)
						step = POS_W'(gap_cfg) + 1;
					else
						step = $urandom_range(gap_cfg);
					cur_pos = cur_pos + step;
				end
				if (pick >= 95)
					cur_pos = $urandom;
				ends = (k == size - 1) ? ($urandom_range(3) == 0) : ($urandom_range(49) == 0);
				send_hit(cur_pos, $urandom_range(99) < fwd_pct, $urandom_range(99) < can_pct,
					ends);
				sent++;
			end
		end
	endtask

	initial begin
		int unsigned n;
		arst_n = 1'b0;
		hit_ch.valid = 1'b0;
		hit_ch.hit_position = '0;
		hit_ch.hit_forward = 1'b0;
		hit_ch.hit_canonical = 1'b0;
		hit_ch.stream_end = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_MERGE_DISTANCE;
		cfg_data = '0;
		send_idle = 15;
		recv_idle = 76;
		gap_cfg = MERGE_DISTANCE_RST;
		cur_pos = $urandom;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_regs(16'd10, 16'd3, 16'd255, 16'd1);
		send_hit(32'd0, 1'b1, 1'b0, 1'b0);
		send_hit(32'd10, 1'b0, 1'b1, 1'b0);    // gap equal to the distance joins
		send_hit(32'd21, 1'b1, 1'b1, 1'b0);    // one past closes an undersized block
		send_hit(32'd21, 1'b0, 1'b0, 1'b0);
		send_hit(32'd25, 1'b1, 1'b0, 1'b0);
		send_hit(32'd30, 1'b1, 1'b1, 1'b1);
		send_hit(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0);
		send_hit(32'd5, 1'b0, 1'b0, 1'b0);     // wraps around, small gap
		send_hit(32'd2, 1'b1, 1'b0, 1'b1);     // backward step closes, then the end closes
		send_hit(32'd100, 1'b0, 1'b1, 1'b1);
		wait_drained(SETTLE_CYCLES);
		write_regs(16'd0, 16'd0, 16'd1, 16'd0);
		send_hit(32'd50, 1'b0, 1'b0, 1'b1);
		send_hit(32'd60, 1'b1, 1'b0, 1'b0);
		send_hit(32'd60, 1'b0, 1'b1, 1'b0);
		send_hit(32'd61, 1'b1, 1'b1, 1'b1);
		for (n = 0; n < 3; n++) begin
			wait_drained(SETTLE_CYCLES);
			random_setting();
			random_blocks(25);
		end

		send_idle = 76;
		recv_idle = 15;
		wait_drained(SETTLE_CYCLES);
		write_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		random_blocks(25);
		for (n = 0; n < 2; n++) begin
			wait_drained(SETTLE_CYCLES);
			random_setting();
			random_blocks(25);
		end

		send_idle = 0;
		recv_idle = 0;
		wait_drained(SETTLE_CYCLES);
		random_setting();
		random_blocks(10);

		wait_drained(END_CYCLES);
		if (mismatch_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end
endmodule
